/* sv/s3rpu_pkg.sv */
// Shared types, round constants and SHA-256 round functions for the three-round precompute.
package s3rpu_pkg;

   localparam int WORD_W    = 32;
   localparam int NUM_WORK  = 8;
   localparam int NUM_MSG   = 3;
   localparam int NUM_ROUND = 3;
   localparam int NUM_PRE   = 6;
   localparam int REQ_W     = (NUM_WORK + NUM_MSG) * WORD_W;
   localparam int RSP_W     = NUM_PRE * WORD_W;

   // Round constants for the first three SHA-256 rounds.
   localparam logic [NUM_ROUND-1:0][WORD_W-1:0] ROUND_K = {
      32'hb5c0fbcf, 32'h71374491, 32'h428a2f98
   };

   // Working words a..h in entries 0..7, plus the schedule words still to be used.
   typedef struct packed {
      logic [NUM_MSG-1:0][WORD_W-1:0]  msg;
      logic [NUM_WORK-1:0][WORD_W-1:0] work;
   } round_state_type;

   function automatic logic [WORD_W-1:0] big_sigma0(input logic [WORD_W-1:0] v);
      big_sigma0 = {v[1:0], v[31:2]} ^ {v[12:0], v[31:13]} ^ {v[21:0], v[31:22]};
   endfunction

   function automatic logic [WORD_W-1:0] big_sigma1(input logic [WORD_W-1:0] v);
      big_sigma1 = {v[5:0], v[31:6]} ^ {v[10:0], v[31:11]} ^ {v[24:0], v[31:25]};
   endfunction

endpackage

/* sv/sha256_three_round_precompute_unit.sv */
// Top level: three-stage pipeline running SHA-256 rounds 0..2 on a midstate.
// Each accepted request passes through the three round-stage registers to rsp_tvalid.
// Throughput: one request per cycle unless the output stalls; each round stage holds one.
// A stalled output backs up stage by stage, and empty stages still accept.
// Reset (synchronous, active high) clears all stage valid bits; no data is kept.
module sha256_three_round_precompute_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_tvalid,
   output logic                          req_tready,
   // mid_word0..mid_word7, msg_word0, msg_word1, msg_word2, 32 bits each from bit 0
   input  logic [s3rpu_pkg::REQ_W-1:0]   req_tdata,
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   // pre_word0..pre_word5, 32 bits each from bit 0
   output logic [s3rpu_pkg::RSP_W-1:0]   rsp_tdata
);

   logic                       [s3rpu_pkg::NUM_ROUND:0] stage_valid;
   logic                       [s3rpu_pkg::NUM_ROUND:0] stage_ready;
   s3rpu_pkg::round_state_type stage_state [s3rpu_pkg::NUM_ROUND+1];

   // Unpack the request into the first stage's working state.
   assign stage_valid[0]    = req_tvalid;
   assign req_tready        = stage_ready[0];
   assign stage_state[0]    = s3rpu_pkg::round_state_type'(req_tdata);

   // One round per stage.
   for (genvar r = 0; r < s3rpu_pkg::NUM_ROUND; r++) begin : g_round
      s3rpu_round u_round (
         .clock    (clock),
         .reset    (reset),
         .round_k  (s3rpu_pkg::ROUND_K[r]),
         .up_valid (stage_valid[r]),
         .up_ready (stage_ready[r]),
         .up_state (stage_state[r]),
         .dn_valid (stage_valid[r+1]),
         .dn_ready (stage_ready[r+1]),
         .dn_state (stage_state[r+1])
      );
   end

   // The last stage register is the output register. After three rounds the new a
   // values sit in words 2..0 and the new e values in words 6..4.
   assign stage_ready[s3rpu_pkg::NUM_ROUND] = rsp_tready;
   assign rsp_tvalid = stage_valid[s3rpu_pkg::NUM_ROUND];
   assign rsp_tdata  = {stage_state[s3rpu_pkg::NUM_ROUND].work[6],
                        stage_state[s3rpu_pkg::NUM_ROUND].work[5],
                        stage_state[s3rpu_pkg::NUM_ROUND].work[4],
                        stage_state[s3rpu_pkg::NUM_ROUND].work[2],
                        stage_state[s3rpu_pkg::NUM_ROUND].work[1],
                        stage_state[s3rpu_pkg::NUM_ROUND].work[0]};

   // A full pipeline with a stalled output must refuse new requests.
   a_full_blocks: assert property (@(posedge clock) disable iff (reset)
      (stage_valid[1] && stage_valid[2] && stage_valid[3] && !rsp_tready) |-> !req_tready)
      else $error("request accepted into a full, stalled pipeline");

   // An accepted request always occupies the first stage next cycle.
   a_enter: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> stage_valid[1])
      else $error("accepted request did not reach the first round stage");

   // A request held behind a stalled full stage is not dropped.
   a_hold_mid: assert property (@(posedge clock) disable iff (reset)
      (stage_valid[2] && stage_valid[3] && !rsp_tready) |=> stage_valid[2])
      else $error("second round stage lost a request during a stall");

   // With the second stage empty and no stalled result at the output, no result shows next cycle.
   a_no_invent: assert property (@(posedge clock) disable iff (reset)
      (!stage_valid[2] && !(stage_valid[3] && !rsp_tready)) |=> !rsp_tvalid)
      else $error("result appeared without a request behind it");

   // Reset empties the output.
   a_reset: assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("result valid right after reset");

endmodule

/* sv/s3rpu_round.sv */
// One SHA-256 compression round as a registered pipeline stage with flow control.
module s3rpu_round (
   input  logic                      clock,
   input  logic                      reset,
   input  logic [s3rpu_pkg::WORD_W-1:0] round_k,
   input  logic                      up_valid,
   output logic                      up_ready,
   input  s3rpu_pkg::round_state_type up_state,
   output logic                      dn_valid,
   input  logic                      dn_ready,
   output s3rpu_pkg::round_state_type dn_state
);

   logic                       valid_ff;
   logic                       valid_in;
   s3rpu_pkg::round_state_type state_ff;
   s3rpu_pkg::round_state_type state_in;
   logic                       load;
   logic [s3rpu_pkg::WORD_W-1:0] ch;
   logic [s3rpu_pkg::WORD_W-1:0] maj;
   logic [s3rpu_pkg::WORD_W-1:0] t1;
   logic [s3rpu_pkg::WORD_W-1:0] t2;

   // The stage takes a new request when empty or when its content leaves this cycle.
   assign up_ready = !valid_ff || dn_ready;
   assign load     = up_valid && up_ready;
   assign valid_in = load ? 1'b1 : (valid_ff && !dn_ready);

   // Round arithmetic; all sums wrap at the word width.
   always_comb begin
      ch  = up_state.work[6] ^ (up_state.work[4] & (up_state.work[5] ^ up_state.work[6]));
      maj = (up_state.work[2] & (up_state.work[0] | up_state.work[1]))
          | (up_state.work[0] & up_state.work[1]);
      t1  = up_state.work[7] + s3rpu_pkg::big_sigma1(up_state.work[4]) + ch + round_k
          + up_state.msg[0];
      t2  = s3rpu_pkg::big_sigma0(up_state.work[0]) + maj;

      state_in.work[7] = up_state.work[6];
      state_in.work[6] = up_state.work[5];
      state_in.work[5] = up_state.work[4];
      state_in.work[4] = up_state.work[3] + t1;
      state_in.work[3] = up_state.work[2];
      state_in.work[2] = up_state.work[1];
      state_in.work[1] = up_state.work[0];
      state_in.work[0] = t1 + t2;

      // The used schedule word drops out and the next one moves to the front.
      state_in.msg[0] = up_state.msg[1];
      state_in.msg[1] = up_state.msg[2];
      state_in.msg[2] = '0;
   end

   // Valid bit with reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Payload register, loaded only on an accepted request.
   always_ff @(posedge clock) begin
      if (load) begin
         state_ff <= state_in;
      end
   end

   assign dn_valid = valid_ff;
   assign dn_state = state_ff;

endmodule
